// ===== sv/pvm_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer package
// Shared types, request codes, controller states and sizing constants.
// ----------------------------------------------------------------------------
package pvm_pkg;

  localparam int DEF_NUM_VOICES   = 16;
  localparam int DEF_NUM_CLIPS    = 16;
  localparam int DEF_SAMPLE_WORDS = 4096;

  localparam logic [15:0] UNITY      = 16'd32768;
  localparam logic [12:0] CURSOR_MAX = 13'd8191;

  typedef enum logic [2:0] {
    REQ_WRITE   = 3'd0,
    REQ_DEFINE  = 3'd1,
    REQ_PLAY    = 3'd2,
    REQ_STOP    = 3'd3,
    REQ_VOLUME  = 3'd4,
    REQ_RENDER  = 3'd5,
    REQ_DESTROY = 3'd6,
    REQ_BAD     = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_CLIP = 2'd1,
    ST_BAD_ARG = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         voice_index;
    logic [3:0]         clip_index;
    logic [11:0]        sample_address;
    logic [12:0]        clip_length;
    logic [3:0]         clip_channels;
    logic signed [15:0] sample_value;
    logic [15:0]        volume_level;
    logic               loop_enable;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [19:0] left_mix;
    logic signed [19:0] right_mix;
    logic               voice_playing;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_VOICE,
    S_READL,
    S_READR,
    S_ACCUM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic do_cmd;
    logic start_render;
    logic voice_step;
    logic issue_left;
    logic issue_right;
    logic accum;
    logic next_voice;
  } cmd_t;

  typedef struct packed {
    logic is_render;
    logic voice_ok;
    logic last_voice;
  } stat_t;

  function automatic logic [15:0] clamp_unity(input logic [15:0] v);
    clamp_unity = (v > UNITY) ? UNITY : v;
  endfunction

endpackage

// ===== sv/pvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer controller
// Sequences one request: a single command strobe, or a walk over all voices.
// ----------------------------------------------------------------------------
module pvm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_take,
  input  logic           hold,
  input  pvm_pkg::stat_t st,
  output pvm_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  import pvm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (in_take) begin
          state_next = S_CMD;
        end
      end
      S_CMD: begin
        if (st.is_render) begin
          cmd.start_render = 1'b1;
          state_next = S_VOICE;
        end else begin
          cmd.do_cmd = 1'b1;
          state_next = S_DONE;
        end
      end
      S_VOICE: begin
        cmd.voice_step = 1'b1;
        if (st.voice_ok) begin
          cmd.issue_left = 1'b1;
          state_next = S_READL;
        end else if (st.last_voice) begin
          state_next = S_DONE;
        end else begin
          cmd.next_voice = 1'b1;
        end
      end
      S_READL: begin
        cmd.issue_right = 1'b1;
        state_next = S_READR;
      end
      S_READR: begin
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        if (st.last_voice) begin
          state_next = S_DONE;
        end else begin
          cmd.next_voice = 1'b1;
          state_next = S_VOICE;
        end
      end
      S_DONE: begin
        if (!hold) begin
          done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/pvm_data.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer datapath
// Sample memory, clip and voice tables, gain multiply and stereo accumulation.
// ----------------------------------------------------------------------------
module pvm_data #(
  parameter int NUM_VOICES   = pvm_pkg::DEF_NUM_VOICES,
  parameter int NUM_CLIPS    = pvm_pkg::DEF_NUM_CLIPS,
  parameter int SAMPLE_WORDS = pvm_pkg::DEF_SAMPLE_WORDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_take,
  input  pvm_pkg::in_item_t  in_item,
  input  logic [15:0]        mix_gain,
  input  pvm_pkg::cmd_t      cmd,
  output pvm_pkg::stat_t     st,
  output pvm_pkg::out_item_t result
);
  import pvm_pkg::*;

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;
  localparam int AW = $clog2(SAMPLE_WORDS);

  in_item_t req;

  logic signed [15:0] sample_mem [SAMPLE_WORDS];
  logic [AW-1:0]      mem_addr;
  logic               mem_rd;
  logic signed [15:0] mem_q;

  logic [NUM_CLIPS-1:0]  clip_valid;
  logic [11:0]           clip_start  [NUM_CLIPS];
  logic [12:0]           clip_size   [NUM_CLIPS];
  logic [3:0]            clip_stride [NUM_CLIPS];
  logic [NUM_VOICES-1:0] voice_active;
  logic [3:0]            voice_clip   [NUM_VOICES];
  logic [12:0]           voice_cursor [NUM_VOICES];
  logic [15:0]           voice_gain   [NUM_VOICES];
  logic [NUM_VOICES-1:0] voice_loop;

  logic [VW-1:0]      vsel;
  logic [CW-1:0]      csel;
  logic [12:0]        cur;
  logic [15:0]        gain;
  logic               dup;
  logic signed [15:0] sl;
  logic signed [19:0] lacc, racc;
  logic [1:0]         status;

  logic               vi_ok, ci_ok, vclip_ok, vok;
  logic [3:0]         vclip;
  logic [12:0]        vcur, vsize, vcur_eff;
  logic [13:0]        cur_sum;
  logic [15:0]        mast;
  logic [31:0]        gprod;
  logic signed [32:0] pl, pr;
  logic [AW-1:0]      base_addr;

  assign vi_ok = (32'(req.voice_index) < NUM_VOICES);
  assign ci_ok = (32'(req.clip_index) < NUM_CLIPS);
  assign vclip = voice_clip[vsel];
  assign vclip_ok = (32'(vclip) < NUM_CLIPS) && clip_valid[CW'(vclip)];
  assign vsize = clip_size[CW'(vclip)];
  assign vcur = voice_cursor[vsel];
  assign vcur_eff = (vcur >= vsize) ? 13'd0 : vcur;
  assign vok = voice_active[vsel] && vclip_ok &&
               ((vcur < vsize) || (voice_loop[vsel] && vsize != 13'd0));
  assign mast = clamp_unity(mix_gain);
  assign gprod = voice_gain[vsel] * mast;
  assign base_addr = AW'(clip_start[CW'(vclip)]);

  assign st.is_render = (req.req_type == REQ_RENDER);
  assign st.voice_ok = vok;
  assign st.last_voice = (32'(vsel) == NUM_VOICES - 1);

  always_comb begin
    mem_rd = cmd.issue_left || cmd.issue_right;
    mem_addr = base_addr + AW'(vcur_eff);
    if (cmd.issue_right) begin
      mem_addr = AW'(clip_start[csel]) + AW'(cur) + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_cmd && req.req_type == REQ_WRITE) begin
      sample_mem[AW'(req.sample_address)] <= req.sample_value;
    end
    if (mem_rd) begin
      mem_q <= sample_mem[mem_addr];
    end
  end

  assign pl = sl * $signed({1'b0, gain});
  assign pr = (dup ? sl : mem_q) * $signed({1'b0, gain});
  assign cur_sum = 14'(cur) + 14'(clip_stride[csel]);

  always_ff @(posedge clk) begin
    if (in_take) begin
      req <= in_item;
    end
    if (rst) begin
      clip_valid <= '0;
      voice_active <= '0;
    end else begin
      if (cmd.do_cmd) begin
        status <= ST_OK;
        lacc <= '0;
        racc <= '0;
        case (req.req_type)
          REQ_WRITE: ;
          REQ_DEFINE: begin
            if (req.clip_channels == 4'd0 || !ci_ok) begin
              status <= ST_BAD_ARG;
            end else begin
              clip_valid[CW'(req.clip_index)] <= 1'b1;
              clip_start[CW'(req.clip_index)] <= req.sample_address;
              clip_size[CW'(req.clip_index)] <= req.clip_length;
              clip_stride[CW'(req.clip_index)] <= req.clip_channels;
            end
          end
          REQ_PLAY: begin
            if (!ci_ok || !clip_valid[CW'(req.clip_index)]) begin
              status <= ST_NO_CLIP;
            end else if (!vi_ok) begin
              status <= ST_BAD_ARG;
            end else begin
              voice_active[VW'(req.voice_index)] <= 1'b1;
              voice_clip[VW'(req.voice_index)] <= req.clip_index;
              voice_cursor[VW'(req.voice_index)] <= '0;
              voice_gain[VW'(req.voice_index)] <= clamp_unity(req.volume_level);
              voice_loop[VW'(req.voice_index)] <= req.loop_enable;
            end
          end
          REQ_STOP: begin
            if (!vi_ok) status <= ST_BAD_ARG;
            else voice_active[VW'(req.voice_index)] <= 1'b0;
          end
          REQ_VOLUME: begin
            if (!vi_ok) status <= ST_BAD_ARG;
            else voice_gain[VW'(req.voice_index)] <= clamp_unity(req.volume_level);
          end
          REQ_DESTROY: begin
            if (!ci_ok) begin
              status <= ST_NO_CLIP;
            end else begin
              for (int k = 0; k < NUM_VOICES; k++) begin
                if (voice_clip[k] == req.clip_index) voice_active[k] <= 1'b0;
              end
              clip_valid[CW'(req.clip_index)] <= 1'b0;
            end
          end
          default: status <= ST_BAD_ARG;
        endcase
      end
      if (cmd.start_render) begin
        status <= ST_OK;
        lacc <= '0;
        racc <= '0;
        vsel <= '0;
      end
      if (cmd.voice_step) begin
        if (!vok) begin
          voice_active[vsel] <= 1'b0;
        end else begin
          csel <= CW'(vclip);
          cur <= vcur_eff;
          gain <= gprod[30:15];
          dup <= !(clip_stride[CW'(vclip)] > 4'd1 && 14'(vcur_eff) + 14'd1 < 14'(vsize));
        end
      end
      if (cmd.issue_right) begin
        sl <= mem_q;
      end
      if (cmd.accum) begin
        lacc <= lacc + 20'(pl >>> 15);
        racc <= racc + 20'(pr >>> 15);
        voice_cursor[vsel] <= (cur_sum > 14'(CURSOR_MAX)) ? CURSOR_MAX : cur_sum[12:0];
      end
      if (cmd.next_voice) begin
        vsel <= vsel + VW'(1);
      end
    end
  end

  assign result.status = status;
  assign result.left_mix = lacc;
  assign result.right_mix = racc;
  assign result.voice_playing = vi_ok && voice_active[VW'(req.voice_index)];

endmodule

// ===== sv/pcm_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// PCM voice mixer
// Multi-voice sample-playback mixer with clip table and stereo render.
// ----------------------------------------------------------------------------
// One request enters on in_valid/in_stall and gives exactly one result on
// out_valid/out_stall. Requests are handled one at a time. A command passes
// through S_CMD and S_DONE before its result is registered. A render walks
// every voice slot in turn: an idle voice is passed over in S_VOICE, while a
// playing voice steps through S_VOICE, S_READL, S_READR and S_ACCUM, for the
// two reads of the single sample memory port and the gain multiply.
// The result sits in an output register. While the receiver stalls it holds,
// and the next request may be transferred meanwhile; its result then waits in
// the controller until the register empties, so one request can be in flight
// behind a waiting result. Reset clears all clips and voices and sets the
// master gain to unity; sample memory contents are kept. The user must write
// mix_gain with cfg_write while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module pcm_voice_mixer #(
  parameter int NUM_VOICES   = pvm_pkg::DEF_NUM_VOICES,
  parameter int NUM_CLIPS    = pvm_pkg::DEF_NUM_CLIPS,
  parameter int SAMPLE_WORDS = pvm_pkg::DEF_SAMPLE_WORDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pvm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pvm_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data
);
  import pvm_pkg::*;

  cmd_t      cmd;
  stat_t     st;
  out_item_t result;
  logic      busy, done, in_take;
  logic      hold;
  logic [15:0] mix_gain;

  assign in_stall = busy;
  assign in_take = in_valid && !in_stall;
  assign hold = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_gain <= UNITY;
    end else if (cfg_write) begin
      mix_gain <= cfg_data;
    end
  end

  pvm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_take (in_take),
    .hold    (hold),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  pvm_data #(
    .NUM_VOICES   (NUM_VOICES),
    .NUM_CLIPS    (NUM_CLIPS),
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_data (
    .clk      (clk),
    .rst      (rst),
    .in_take  (in_take),
    .in_item  (in_data),
    .mix_gain (mix_gain),
    .cmd      (cmd),
    .st       (st),
    .result   (result)
  );

  // Output register; the controller holds in its final state until it empties.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (done) begin
      out_data <= result;
    end
  end

  property p_done_not_lost;
    @(posedge clk) disable iff (rst) (done && !hold) |=> out_valid;
  endproperty
  a_done_not_lost: assert property (p_done_not_lost)
    else $error("finished result not presented");

  property p_busy_while_cmd;
    @(posedge clk) disable iff (rst) (cmd.do_cmd || cmd.voice_step) |-> busy;
  endproperty
  a_busy_while_cmd: assert property (p_busy_while_cmd)
    else $error("datapath command while idle");

  property p_done_idle;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_idle: assert property (p_done_idle)
    else $error("double completion");

endmodule
